@@ hdl/mslre_pkg.sv @@
// ----------------------------------------------------------------------------
// mslre_pkg
// shared types and codes of the multi-slot linear ramp engine
// ----------------------------------------------------------------------------
package mslre_pkg;

   // request commands
   localparam logic [2:0] CMD_CREATE_FRAC = 3'd0;
   localparam logic [2:0] CMD_CREATE_INT  = 3'd1;
   localparam logic [2:0] CMD_START       = 3'd2;
   localparam logic [2:0] CMD_STOP        = 3'd3;
   localparam logic [2:0] CMD_TICK        = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_IDLE   = 2'd2;

   // divider operand widths
   localparam int DIVIDEND_W = 50;
   localparam int DIVISOR_W  = 16;

   typedef struct packed {
      logic               is_int;
      logic signed [31:0] start_val;
      logic signed [31:0] end_val;
      logic [15:0]        length;
      logic [16:0]        elapsed;
   } slot_entry_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_MUL    = 7'b0001000,
      ST_DSTART = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

endpackage

@@ hdl/mslre_req_if.sv @@
// ----------------------------------------------------------------------------
// mslre_req_if
// request channel of the ramp engine: command and its operands
// ----------------------------------------------------------------------------
interface mslre_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic [3:0]         slot;
   logic signed [31:0] start_value;
   logic signed [31:0] end_value;
   logic [15:0]        duration;
   logic [15:0]        time_step;

   modport source (
      output valid, command, slot, start_value, end_value, duration, time_step,
      input  ready
   );
   modport sink (
      input  valid, command, slot, start_value, end_value, duration, time_step,
      output ready
   );
endinterface

@@ hdl/mslre_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mslre_rsp_if
// result channel of the ramp engine: create replies and slot updates
// ----------------------------------------------------------------------------
interface mslre_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [3:0]         slot_id;
   logic signed [31:0] value;
   logic               finished;
   logic               alloc_failed;
   logic               last;

   modport source (
      output valid, kind, slot_id, value, finished, alloc_failed, last,
      input  ready
   );
   modport sink (
      input  valid, kind, slot_id, value, finished, alloc_failed, last,
      output ready
   );
endinterface

@@ hdl/mslre_ram.sv @@
// ----------------------------------------------------------------------------
// mslre_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module mslre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/mslre_div.sv @@
// ----------------------------------------------------------------------------
// mslre_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mslre_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mslre_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [mslre_pkg::DIVISOR_W-1:0]     divisor,
   output logic                                done,
   output logic [mslre_pkg::DIVIDEND_W-1:0]    quotient
);
   import mslre_pkg::*;

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, divisor};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // quotient bits shift in where dividend bits leave
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ hdl/multi_slot_linear_ramp_engine.sv @@
// ----------------------------------------------------------------------------
// multi_slot_linear_ramp_engine
// table of linear ramp slots stepped by tick requests
// ----------------------------------------------------------------------------
// Slot parameters and elapsed time live in one memory; in-use and running
// flags are flip-flops. Create waits for the result register; start and stop
// give no result. A tick walks the table one slot per cycle and, for each
// running slot, stops for a memory read and, unless the ramp has ended, a
// 33x18 multiply and a 50-step serial divide by the duration, then waits for
// the result register. Results wait in an output register and one new
// request is taken once the previous one has finished its work.
module multi_slot_linear_ramp_engine #(
   parameter int SLOT_COUNT = 16
) (
   input  logic          clock,
   input  logic          reset,
   mslre_req_if.sink     req_chan,
   mslre_rsp_if.source   rsp_chan
);
   import mslre_pkg::*;

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int EW = $bits(slot_entry_type);

   state_type             state_ff, state_in;
   logic [SW-1:0]         idx_ff, idx_in;
   logic [15:0]           step_ff, step_in;
   logic [1:0]            kind_ff, kind_in;
   logic                  free_ok_ff, free_ok_in;
   logic [SW-1:0]         free_idx_ff, free_idx_in;
   slot_entry_type        new_entry_ff, new_entry_in;
   slot_entry_type        entry_ff, entry_in;
   logic [16:0]           el_new_ff, el_new_in;
   logic                  done_ff, done_in;
   logic signed [32:0]    diff_ff, diff_in;
   logic signed [50:0]    prod_ff, prod_in;
   logic signed [31:0]    value_ff, value_in;
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [SLOT_COUNT-1:0] running_ff, running_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [3:0]            rsp_slot_ff, rsp_slot_in;
   logic signed [31:0]    rsp_value_ff, rsp_value_in;
   logic                  rsp_fin_ff, rsp_fin_in;
   logic                  rsp_fail_ff, rsp_fail_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  out_free;
   logic                  slot_ok;
   logic [SW-1:0]         slot_sel;
   logic [SLOT_COUNT-1:0] active;
   logic                  later_active;
   logic                  free_found;
   logic [SW-1:0]         free_idx;
   logic [16:0]           el_sum;
   logic signed [17:0]    el_s;
   logic                  prod_neg;
   logic [50:0]           prod_abs;
   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quo;
   logic signed [32:0]    quo_s;
   logic signed [32:0]    sum_v;
   logic signed [32:0]    v_ext;
   logic [32:0]           v_mag;
   logic signed [31:0]    out_value;
   logic                  ram_we;
   logic [SW-1:0]         ram_waddr;
   slot_entry_type        ram_wdata;
   logic                  ram_re;
   logic [EW-1:0]         ram_rdata;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign slot_ok  = int'(req_chan.slot) < SLOT_COUNT;
   assign slot_sel = SW'(req_chan.slot);
   assign active   = in_use_ff & running_ff;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
         if (!in_use_ff[j]) begin
            free_found = 1'b1;
            free_idx   = SW'(j);
         end
      end
   end

   always_comb begin
      later_active = 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
         if (active[j] && (j > int'(idx_ff))) begin
            later_active = 1'b1;
         end
      end
   end

   // elapsed update and interpolation datapath
   assign el_sum   = entry_in.elapsed + 17'(step_ff);
   assign el_s     = $signed({1'b0, el_new_ff});
   assign prod_in  = diff_ff * el_s;
   assign prod_neg = prod_ff[50];
   assign prod_abs = prod_neg ? (51'd0 - 51'(prod_ff)) : 51'(prod_ff);
   assign quo_s    = prod_neg ? -$signed(div_quo[32:0]) : $signed(div_quo[32:0]);
   assign sum_v    = $signed({entry_ff.start_val[31], entry_ff.start_val}) + quo_s;

   // integer slots drop the fraction toward zero
   always_comb begin
      v_ext     = $signed({value_ff[31], value_ff});
      v_mag     = value_ff[31] ? 33'(-v_ext) : 33'(v_ext);
      v_mag     = v_mag & ~33'h0FFFF;
      out_value = value_ff;
      if (entry_ff.is_int) begin
         out_value = value_ff[31] ? 32'(33'd0 - v_mag) : v_mag[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      kind_in      = kind_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      new_entry_in = new_entry_ff;
      entry_in     = entry_ff;
      el_new_in    = el_new_ff;
      done_in      = done_ff;
      diff_in      = diff_ff;
      value_in     = value_ff;
      in_use_in    = in_use_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_value_in = rsp_value_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_fail_in  = rsp_fail_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = entry_ff;
      ram_re       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in = req_chan.time_step;
               idx_in  = '0;
               unique case (req_chan.command) inside
                  CMD_CREATE_FRAC, CMD_CREATE_INT: begin
                     kind_in                = KIND_CREATE;
                     free_ok_in             = free_found;
                     free_idx_in            = free_idx;
                     new_entry_in.is_int    = (req_chan.command == CMD_CREATE_INT);
                     new_entry_in.start_val = req_chan.start_value;
                     new_entry_in.end_val   = req_chan.end_value;
                     new_entry_in.length    = req_chan.duration;
                     new_entry_in.elapsed   = '0;
                     state_in               = ST_EMIT;
                  end
                  CMD_START: begin
                     if (slot_ok && in_use_ff[slot_sel]) begin
                        running_in[slot_sel] = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     if (slot_ok) begin
                        in_use_in[slot_sel]  = 1'b0;
                        running_in[slot_sel] = 1'b0;
                     end
                  end
                  CMD_TICK: begin
                     if (|active) begin
                        kind_in  = KIND_UPDATE;
                        state_in = ST_SCAN;
                     end else begin
                        kind_in  = KIND_IDLE;
                        state_in = ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (active[idx_ff]) begin
               ram_re   = 1'b1;
               state_in = ST_READ;
            end else if (idx_ff == SW'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_READ: begin
            entry_in  = slot_entry_type'(ram_rdata);
            el_new_in = el_sum;
            done_in   = el_sum >= {1'b0, entry_in.length};
            diff_in   = $signed({entry_in.end_val[31], entry_in.end_val})
                        - $signed({entry_in.start_val[31], entry_in.start_val});
            value_in  = entry_in.end_val;
            state_in  = (el_sum >= {1'b0, entry_in.length}) ? ST_EMIT : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               value_in = sum_v[31:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_slot_in  = '0;
               rsp_value_in = '0;
               rsp_fin_in   = 1'b0;
               rsp_fail_in  = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               case (kind_ff)
                  KIND_CREATE: begin
                     rsp_fail_in = !free_ok_ff;
                     if (free_ok_ff) begin
                        rsp_slot_in              = 4'(free_idx_ff);
                        ram_we                   = 1'b1;
                        ram_waddr                = free_idx_ff;
                        ram_wdata                = new_entry_ff;
                        in_use_in[free_idx_ff]   = 1'b1;
                        running_in[free_idx_ff]  = 1'b0;
                     end
                  end
                  KIND_UPDATE: begin
                     rsp_slot_in       = 4'(idx_ff);
                     rsp_value_in      = out_value;
                     rsp_fin_in        = done_ff;
                     rsp_last_in       = !later_active;
                     ram_we            = 1'b1;
                     ram_wdata         = entry_ff;
                     ram_wdata.elapsed = el_new_ff;
                     if (done_ff) begin
                        in_use_in[idx_ff]  = 1'b0;
                        running_in[idx_ff] = 1'b0;
                     end
                     if (later_active) begin
                        idx_in   = idx_ff + 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      kind_ff      <= kind_in;
      free_ok_ff   <= free_ok_in;
      free_idx_ff  <= free_idx_in;
      new_entry_ff <= new_entry_in;
      entry_ff     <= entry_in;
      el_new_ff    <= el_new_in;
      done_ff      <= done_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      value_ff     <= value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_fail_ff  <= rsp_fail_in;
      rsp_last_ff  <= rsp_last_in;
   end

   mslre_ram #(
      .WIDTH (EW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (EW'(ram_wdata)),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   mslre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_abs[DIVIDEND_W-1:0]),
      .divisor  (entry_ff.length),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.slot_id      = rsp_slot_ff;
   assign rsp_chan.value        = rsp_value_ff;
   assign rsp_chan.finished     = rsp_fin_ff;
   assign rsp_chan.alloc_failed = rsp_fail_ff;
   assign rsp_chan.last         = rsp_last_ff;
endmodule

@@ bench/mslre_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// mslre_tb_pkg
// request and result records used by the ramp engine testbench
// ----------------------------------------------------------------------------
package mslre_tb_pkg;

   typedef struct {
      logic [2:0]         command;
      logic [3:0]         slot;
      logic signed [31:0] start_value;
      logic signed [31:0] end_value;
      logic [15:0]        duration;
      logic [15:0]        time_step;
   } ramp_req_type;

   typedef struct {
      logic [1:0]         kind;
      logic [3:0]         slot_id;
      logic signed [31:0] value;
      logic               finished;
      logic               alloc_failed;
      logic               last;
   } ramp_rsp_type;

endpackage

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the multi-slot linear ramp engine: directed and
// random create/start/stop/tick requests, results predicted from a slot-table
// model and compared field by field, with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;
   import mslre_pkg::*;
   import mslre_tb_pkg::*;

   localparam int SLOTS = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mslre_req_if req_chan ();
   mslre_rsp_if rsp_chan ();

   multi_slot_linear_ramp_engine #(.SLOT_COUNT(SLOTS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   // prediction state
   logic               model_in_use  [SLOTS];
   logic               model_running [SLOTS];
   logic               model_is_int  [SLOTS];
   logic signed [31:0] model_begin   [SLOTS];
   logic signed [31:0] model_end     [SLOTS];
   logic [15:0]        model_length  [SLOTS];
   logic [16:0]        model_elapsed [SLOTS];

   ramp_req_type pending_reqs [$];
   ramp_rsp_type expected_rsps [$];
   int        error_count = 0;
   int        send_idle_pct = 35;
   int        recv_idle_pct = 51;
   bit        hold_off = 1'b0;

   function automatic ramp_rsp_type make_rsp(logic [1:0] kind, logic [3:0] id,
                                             logic signed [31:0] value,
                                             logic fin, logic fail, logic last);
      ramp_rsp_type r;
      r.kind = kind; r.slot_id = id; r.value = value;
      r.finished = fin; r.alloc_failed = fail; r.last = last;
      return r;
   endfunction

   function automatic logic signed [31:0] ramp_value(int i);
      longint b, e, v;
      b = model_begin[i];
      e = model_end[i];
      if (model_elapsed[i] >= {1'b0, model_length[i]}) v = e;
      else v = b + ((e - b) * longint'(model_elapsed[i])) / longint'(model_length[i]);
      if (model_is_int[i]) begin
         if (v < 0) v = -((-v) & ~longint'(16'hFFFF));
         else v = v & ~longint'(16'hFFFF);
      end
      return v[31:0];
   endfunction

   // advance the slot table by one accepted request and queue its results
   task automatic predict_ramp(ramp_req_type q);
      int n;
      int found;
      logic fin;
      logic signed [31:0] v;
      n = 0;
      found = -1;
      case (q.command) inside
         CMD_CREATE_FRAC, CMD_CREATE_INT: begin
            for (int i = 0; i < SLOTS; i++)
               if (found < 0 && !model_in_use[i]) found = i;
            if (found < 0) begin
               expected_rsps.push_back(make_rsp(KIND_CREATE, 0, 0, 0, 1, 1));
            end else begin
               model_in_use[found]  = 1;
               model_running[found] = 0;
               model_is_int[found]  = (q.command == CMD_CREATE_INT);
               model_begin[found]   = q.start_value;
               model_end[found]     = q.end_value;
               model_length[found]  = q.duration;
               model_elapsed[found] = 0;
               expected_rsps.push_back(make_rsp(KIND_CREATE, found[3:0], 0, 0, 0, 1));
            end
         end
         CMD_START: begin
            if (model_in_use[q.slot]) model_running[q.slot] = 1;
         end
         CMD_STOP: begin
            model_in_use[q.slot] = 0;
            model_running[q.slot] = 0;
            model_elapsed[q.slot] = 0;
         end
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (model_in_use[i] && model_running[i]) begin
                  model_elapsed[i] = model_elapsed[i] + {1'b0, q.time_step};
                  v = ramp_value(i);
                  fin = model_elapsed[i] >= {1'b0, model_length[i]};
                  if (fin) begin
                     model_in_use[i] = 0;
                     model_running[i] = 0;
                     model_elapsed[i] = 0;
                  end
                  expected_rsps.push_back(make_rsp(KIND_UPDATE, i[3:0], v, fin, 0, 0));
                  n++;
               end
            end
            if (n == 0) expected_rsps.push_back(make_rsp(KIND_IDLE, 0, 0, 0, 0, 1));
            else expected_rsps[$].last = 1;
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            model_in_use[i] = 0; model_running[i] = 0; model_is_int[i] = 0;
            model_begin[i] = 0; model_end[i] = 0; model_length[i] = 0;
            model_elapsed[i] = 0;
         end
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) predict_ramp(pending_reqs.pop_front());
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid       <= 1'b1;
            req_chan.command     <= pending_reqs[0].command;
            req_chan.slot        <= pending_reqs[0].slot;
            req_chan.start_value <= pending_reqs[0].start_value;
            req_chan.end_value   <= pending_reqs[0].end_value;
            req_chan.duration    <= pending_reqs[0].duration;
            req_chan.time_step   <= pending_reqs[0].time_step;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver holds off for a long stretch right after reset, so requests back up
   initial begin
      @(negedge reset);
      hold_off <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_off <= 1'b0;
   end

   // monitor and receiver idling
   always @(posedge clock) begin
      ramp_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result kind %0d slot %0d value %0d", $time,
                        rsp_chan.kind, rsp_chan.slot_id, rsp_chan.value);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_chan.kind !== want.kind || rsp_chan.slot_id !== want.slot_id ||
                   rsp_chan.value !== want.value || rsp_chan.finished !== want.finished ||
                   rsp_chan.alloc_failed !== want.alloc_failed ||
                   rsp_chan.last !== want.last) begin
                  $display("%0t: mismatch expected k%0d s%0d v%0d f%0d a%0d l%0d", $time,
                           want.kind, want.slot_id, want.value, want.finished,
                           want.alloc_failed, want.last);
                  $display("%0t:            actual k%0d s%0d v%0d f%0d a%0d l%0d", $time,
                           rsp_chan.kind, rsp_chan.slot_id, rsp_chan.value,
                           rsp_chan.finished, rsp_chan.alloc_failed, rsp_chan.last);
                  error_count++;
               end
            end
         end
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic ramp_req_type req(logic [2:0] c, logic [3:0] s, logic [31:0] b,
                                        logic [31:0] e, logic [15:0] d, logic [15:0] t);
      ramp_req_type q;
      q.command = c; q.slot = s; q.start_value = b; q.end_value = e;
      q.duration = d; q.time_step = t;
      return q;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // a ramp burst: create, start on a random low slot, a few ticks, sometimes a stop
   task automatic push_ramp_burst();
      logic [15:0] d;
      int ticks;
      d = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
      pending_reqs.push_back(req(3'($urandom_range(1)), 0, rand_value(), rand_value(),
                                 d, 0));
      pending_reqs.push_back(req(CMD_START, 4'($urandom_range(5)), 0, 0, 0, 0));
      ticks = $urandom_range(3);
      for (int k = 0; k < ticks; k++)
         pending_reqs.push_back(req(CMD_TICK, 0, 0, 0, 0,
                                    ($urandom_range(7) == 0) ? 16'($urandom())
                                                             : 16'($urandom_range(12))));
      if ($urandom_range(3) == 0)
         pending_reqs.push_back(req(CMD_STOP, 4'($urandom_range(15)), 0, 0, 0, 0));
   endtask

   task automatic wait_drain();
      while (pending_reqs.size() > 0 || req_chan.valid) @(posedge clock);
   endtask

   initial begin
      int sent;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, extremes, zero duration, integer mode, full table
      pending_reqs.push_back(req(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));
      pending_reqs.push_back(req(CMD_CREATE_FRAC, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                 16'hFFFF, 0));
      pending_reqs.push_back(req(CMD_CREATE_INT, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                 16'd3, 0));
      pending_reqs.push_back(req(CMD_CREATE_INT, 0, 32'hFFFE_8001, 32'h0003_0000, 0, 0));
      pending_reqs.push_back(req(CMD_START, 0, 0, 0, 0, 0));
      pending_reqs.push_back(req(CMD_START, 1, 0, 0, 0, 0));
      pending_reqs.push_back(req(CMD_START, 2, 0, 0, 0, 0));
      pending_reqs.push_back(req(CMD_START, 9, 0, 0, 0, 0));
      pending_reqs.push_back(req(CMD_TICK, 0, 0, 0, 0, 16'd1));
      pending_reqs.push_back(req(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));
      pending_reqs.push_back(req(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));
      pending_reqs.push_back(req(CMD_STOP, 15, 0, 0, 0, 0));
      pending_reqs.push_back(req(3'd7, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                 16'hFFFF));
      pending_reqs.push_back(req(3'd5, 0, 0, 0, 0, 0));
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(req({2'b00, i[0]}, 0, $urandom(), $urandom(), 16'd5, 0));
      for (int i = 0; i < 16; i++)
         pending_reqs.push_back(req(CMD_START, i[3:0], 0, 0, 0, 0));
      for (int i = 0; i < 3; i++)
         pending_reqs.push_back(req(CMD_TICK, 0, 0, 0, 0, 16'd2));
      wait_drain();

      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 35 : 0;
         while (sent < 70 * (phase + 1)) begin
            if ($urandom_range(4) == 0)
               pending_reqs.push_back(req(3'($urandom_range(7)), 4'($urandom()),
                                          $urandom(), $urandom(), 16'($urandom()),
                                          16'($urandom())));
            else
               push_ramp_burst();
            sent = sent + 4;
            wait_drain();
         end
      end
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
hdl/mslre_pkg.sv
hdl/mslre_req_if.sv
hdl/mslre_rsp_if.sv
hdl/mslre_ram.sv
hdl/mslre_div.sv
hdl/multi_slot_linear_ramp_engine.sv
bench/mslre_tb_pkg.sv
bench/testbench.sv
